[src/sum_checksum_frame_receiver_defines.svh]
// assertion macros for the frame receiver checker
`ifndef SUM_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define SUM_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, held off during reset
`define SCFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scfr assertion failed");

// next-cycle implication, held off during reset
`define SCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scfr assertion failed");

`endif

[src/scfr_pkg.sv]
// types and constants for the additive checksum frame receiver
package scfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;
    localparam logic [BYTE_W-1:0] DATA_HDR = 8'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK   = 2'd3;

    localparam logic [BYTE_W-1:0] START_RST = 8'd2;
    localparam logic [BYTE_W-1:0] END_RST   = 8'd3;
    localparam logic [BYTE_W-1:0] ACK_RST   = 8'd6;
    localparam logic [BYTE_W-1:0] NAK_RST   = 8'd21;

    // field kinds reported per byte
    localparam logic [KIND_W-1:0] KIND_SKIP     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MSGID    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RESP     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_TYPE     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DATA     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_ERRCODE  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CHECKSUM = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END      = 4'd8;

    typedef enum logic [8:0] {
        PH_START    = 9'b000000001,
        PH_LENGTH   = 9'b000000010,
        PH_MSGID    = 9'b000000100,
        PH_RESP     = 9'b000001000,
        PH_TYPE     = 9'b000010000,
        PH_DATA     = 9'b000100000,
        PH_ERRCODE  = 9'b001000000,
        PH_CHECKSUM = 9'b010000000,
        PH_END      = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] start_char;
        logic [BYTE_W-1:0] end_char;
        logic [BYTE_W-1:0] ack_char;
        logic [BYTE_W-1:0] nak_char;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] field_kind;
        logic [BYTE_W-1:0] field_byte;
        logic              frame_done;
        logic              frame_good;
        logic              checksum_ok;
        logic              was_ack;
    } t_result;

endpackage

[src/scfr_rx_if.sv]
// byte input channel
interface scfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[src/scfr_res_if.sv]
// classified byte result channel
interface scfr_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_kind;
    logic [7:0] field_byte;
    logic       frame_done;
    logic       frame_good;
    logic       checksum_ok;
    logic       was_ack;

    modport source (output valid, output field_kind, output field_byte,
                    output frame_done, output frame_good, output checksum_ok,
                    output was_ack, input ready);
    modport sink (input valid, input field_kind, input field_byte,
                  input frame_done, input frame_good, input checksum_ok,
                  input was_ack, output ready);
endinterface

[src/scfr_cfg_regs.sv]
// configuration registers for the frame receiver
module scfr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [scfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scfr_pkg::BYTE_W-1:0]      i_cfg_data,
    output scfr_pkg::t_cfg                   o_cfg
);
    import scfr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START: n_cfg.start_char = i_cfg_data;
                CFG_END:   n_cfg.end_char   = i_cfg_data;
                CFG_ACK:   n_cfg.ack_char   = i_cfg_data;
                CFG_NAK:   n_cfg.nak_char   = i_cfg_data;
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_char <= START_RST;
            r_cfg.end_char   <= END_RST;
            r_cfg.ack_char   <= ACK_RST;
            r_cfg.nak_char   <= NAK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

[src/scfr_parser.sv]
// frame parse state and per-byte classification
module scfr_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [scfr_pkg::BYTE_W-1:0]  i_byte,
    input  scfr_pkg::t_cfg               i_cfg,
    output scfr_pkg::t_result            o_res
);
    import scfr_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_ack, n_ack;
    logic [BYTE_W-1:0] sum_add;
    logic              sum_match;

    assign sum_add   = r_sum + i_byte;
    assign sum_match = (r_sum == SUM_GOOD);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_ack   = r_ack;
        o_res.field_kind  = KIND_SKIP;
        o_res.field_byte  = i_byte;
        o_res.frame_done  = 1'b0;
        o_res.frame_good  = 1'b0;
        o_res.checksum_ok = 1'b0;
        case (r_phase)
            PH_LENGTH: begin
                o_res.field_kind = KIND_LENGTH;
                n_len   = i_byte;
                n_phase = PH_MSGID;
            end
            PH_MSGID: begin
                o_res.field_kind = KIND_MSGID;
                n_sum   = i_byte;
                n_phase = PH_RESP;
            end
            PH_RESP: begin
                o_res.field_kind = KIND_RESP;
                n_sum   = sum_add;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                // unknown type bytes are dropped, keep waiting
                if (i_byte == i_cfg.ack_char) begin
                    o_res.field_kind = KIND_TYPE;
                    n_sum   = sum_add;
                    n_ack   = 1'b1;
                    n_cnt   = '0;
                    n_phase = (r_len > DATA_HDR) ? PH_DATA : PH_CHECKSUM;
                end else if (i_byte == i_cfg.nak_char) begin
                    o_res.field_kind = KIND_TYPE;
                    n_sum   = sum_add;
                    n_ack   = 1'b0;
                    n_phase = PH_ERRCODE;
                end
            end
            PH_DATA: begin
                o_res.field_kind = KIND_DATA;
                n_sum = sum_add;
                n_cnt = r_cnt + 8'd1;
                if (n_cnt == r_len - DATA_HDR) begin
                    n_phase = PH_CHECKSUM;
                end
            end
            PH_ERRCODE: begin
                o_res.field_kind = KIND_ERRCODE;
                n_sum   = sum_add;
                n_phase = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
                o_res.field_kind = KIND_CHECKSUM;
                n_sum   = sum_add;
                n_phase = PH_END;
            end
            PH_END: begin
                o_res.field_kind  = KIND_END;
                o_res.frame_done  = 1'b1;
                o_res.checksum_ok = sum_match;
                o_res.frame_good  = sum_match && (i_byte == i_cfg.end_char);
                n_phase = PH_START;
            end
            default: begin
                // hunting for the start byte
                if (i_byte == i_cfg.start_char) begin
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_ack   = 1'b0;
                    n_phase = PH_LENGTH;
                end else begin
                    n_phase = PH_START;
                end
            end
        endcase
        o_res.was_ack = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_ack   <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_ack   <= n_ack;
        end
    end
endmodule

[src/sum_checksum_frame_receiver.sv]
// additive checksum frame receiver: byte register, parser, result register
// an accepted byte goes through the byte register and the parser into the result register
// throughput: one byte per cycle while the output is not stalled; the parse state advances with each byte
// a stalled output backs up through the byte register to the input ready
// reset: synchronous, active low; valid flags, parse state and configuration
// return to their defaults and the parser hunts for the start byte again
module sum_checksum_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scfr_pkg::BYTE_W-1:0]     i_cfg_data,
    scfr_rx_if.sink                         i_rx,
    scfr_res_if.source                      o_res
);
    import scfr_pkg::*;

    t_cfg              cfg;
    t_result           parse_res;
    logic              r_s0_valid;
    logic [BYTE_W-1:0] r_s0_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              out_load;
    logic              s0_load;

    // result register takes a byte when empty or being drained
    assign out_load = r_s0_valid && (!r_out_valid || o_res.ready);
    assign s0_load  = !r_s0_valid || out_load;

    scfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    scfr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (out_load),
        .i_byte  (r_s0_byte),
        .i_cfg   (cfg),
        .o_res   (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s0_load) begin
                r_s0_valid <= i_rx.valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_load && i_rx.valid) begin
            r_s0_byte <= i_rx.rx_byte;
        end
        if (out_load) begin
            r_out <= parse_res;
        end
    end

    assign i_rx.ready        = s0_load;
    assign o_res.valid       = r_out_valid;
    assign o_res.field_kind  = r_out.field_kind;
    assign o_res.field_byte  = r_out.field_byte;
    assign o_res.frame_done  = r_out.frame_done;
    assign o_res.frame_good  = r_out.frame_good;
    assign o_res.checksum_ok = r_out.checksum_ok;
    assign o_res.was_ack     = r_out.was_ack;
endmodule

[src/scfr_checker.sv]
// port-level checks for the frame receiver, bound to the top level
`include "sum_checksum_frame_receiver_defines.svh"

module scfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_field_kind,
    input logic [7:0] i_field_byte,
    input logic       i_frame_done,
    input logic       i_frame_good,
    input logic       i_checksum_ok
);
    import scfr_pkg::*;

    // a good frame needs a good checksum and the end position
    `SCFR_ASSERT_SAME(a_good_needs_ok, i_clk, i_rst_n, i_out_valid && i_frame_good, i_checksum_ok && i_frame_done)

    // checksum flag only shows on the end byte
    `SCFR_ASSERT_SAME(a_ok_at_end, i_clk, i_rst_n, i_out_valid && i_checksum_ok, i_field_kind == KIND_END)

    // the end kind implies the end position
    `SCFR_ASSERT_SAME(a_done_is_end, i_clk, i_rst_n, i_out_valid && (i_field_kind == KIND_END), i_frame_done)

    // a stalled result keeps its byte
    `SCFR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_field_byte))
endmodule

bind sum_checksum_frame_receiver scfr_checker u_scfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_field_kind  (o_res.field_kind),
    .i_field_byte  (o_res.field_byte),
    .i_frame_done  (o_res.frame_done),
    .i_frame_good  (o_res.frame_good),
    .i_checksum_ok (o_res.checksum_ok)
);

[tb/testbench.sv]
// self-checking testbench for the additive checksum frame receiver
module testbench;
    import scfr_pkg::*;

    localparam int PHASE_ITEMS  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_ROWS       = 26;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              typed;
        t_result           want;
    } t_row;

    // reset register values throughout; '0 rows are left to the predictor
    localparam t_row DIRECTED [N_ROWS] = '{
        '{8'h00, 1'b1, '{KIND_SKIP,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h02, 1'b1, '{KIND_SKIP,     8'h02, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h05, 1'b1, '{KIND_LENGTH,   8'h05, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h10, 1'b0, '0},
        '{8'h20, 1'b0, '0},
        '{8'h99, 1'b1, '{KIND_SKIP,     8'h99, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h06, 1'b1, '{KIND_TYPE,     8'h06, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'h00, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h49, 1'b0, '0},
        '{8'h03, 1'b1, '{KIND_END,      8'h03, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{8'h02, 1'b1, '{KIND_SKIP,     8'h02, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, '{KIND_LENGTH,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h15, 1'b1, '{KIND_TYPE,     8'h15, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h5A, 1'b1, '{KIND_ERRCODE,  8'h5A, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h91, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_END,      8'hFF, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{8'h02, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h06, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_CHECKSUM, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'h03, 1'b1, '{KIND_END,      8'h03, 1'b1, 1'b0, 1'b0, 1'b1}}
    };

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 sink_ready = 1'b0;
    logic [9:0]           stall_cnt = '0;

    scfr_rx_if  rx_ch();
    scfr_res_if res_ch();

    assign res_ch.ready = sink_ready;

    sum_checksum_frame_receiver i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    // parser model state
    t_cfg              cfg_model;
    t_phase            phase_model;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] data_seen;
    logic [BYTE_W-1:0] byte_sum;
    logic              ack_flag;

    t_result     expected_fields[$];
    int unsigned items_sent = 0;
    int unsigned fail_count = 0;
    int          burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("sum_checksum_frame_receiver test failed");
        $finish;
    end

    function automatic void reset_model();
        cfg_model   = '{START_RST, END_RST, ACK_RST, NAK_RST};
        phase_model = PH_START;
        frame_len   = '0;
        data_seen   = '0;
        byte_sum    = '0;
        ack_flag    = 1'b0;
    endfunction

    function automatic t_result classify_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        r = '0;
        r.field_byte = b;
        case (phase_model)
            PH_LENGTH: begin
                r.field_kind = KIND_LENGTH;
                frame_len    = b;
                phase_model  = PH_MSGID;
            end
            PH_MSGID: begin
                r.field_kind = KIND_MSGID;
                byte_sum     = b;
                phase_model  = PH_RESP;
            end
            PH_RESP: begin
                r.field_kind = KIND_RESP;
                byte_sum     = byte_sum + b;
                phase_model  = PH_TYPE;
            end
            PH_TYPE: begin
                // acknowledge wins when both type bytes are equal
                if (b == cfg_model.ack_char) begin
                    r.field_kind = KIND_TYPE;
                    byte_sum     = byte_sum + b;
                    ack_flag     = 1'b1;
                    data_seen    = '0;
                    phase_model  = (frame_len > DATA_HDR) ? PH_DATA : PH_CHECKSUM;
                end else if (b == cfg_model.nak_char) begin
                    r.field_kind = KIND_TYPE;
                    byte_sum     = byte_sum + b;
                    ack_flag     = 1'b0;
                    phase_model  = PH_ERRCODE;
                end
            end
            PH_DATA: begin
                r.field_kind = KIND_DATA;
                byte_sum     = byte_sum + b;
                data_seen    = data_seen + 8'd1;
                if (data_seen == frame_len - DATA_HDR)
                    phase_model = PH_CHECKSUM;
            end
            PH_ERRCODE: begin
                r.field_kind = KIND_ERRCODE;
                byte_sum     = byte_sum + b;
                phase_model  = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
                r.field_kind = KIND_CHECKSUM;
                byte_sum     = byte_sum + b;
                phase_model  = PH_END;
            end
            PH_END: begin
                r.field_kind  = KIND_END;
                r.frame_done  = 1'b1;
                r.checksum_ok = (byte_sum == SUM_GOOD);
                r.frame_good  = r.checksum_ok && (b == cfg_model.end_char);
                phase_model   = PH_START;
            end
            default: begin
                if (b == cfg_model.start_char) begin
                    byte_sum    = '0;
                    data_seen   = '0;
                    ack_flag    = 1'b0;
                    phase_model = PH_LENGTH;
                end else begin
                    phase_model = PH_START;
                end
            end
        endcase
        r.was_ack = ack_flag;
        return r;
    endfunction

    // bursts of transfers with random gaps in between
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input t_result want);
        int gap;
        t_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        r = classify_byte(b);
        expected_fields.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        rx_ch.valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START: cfg_model.start_char = val;
            CFG_END:   cfg_model.end_char   = val;
            CFG_ACK:   cfg_model.ack_char   = val;
            default:   cfg_model.nak_char   = val;
        endcase
    endtask

    task automatic write_all(input t_cfg c);
        write_reg(CFG_START, c.start_char);
        write_reg(CFG_END, c.end_char);
        write_reg(CFG_ACK, c.ack_char);
        write_reg(CFG_NAK, c.nak_char);
    endtask

    // mostly well-formed frames; some noise, bad sums, bad end bytes and cut-off frames
    task automatic send_frame();
        logic [BYTE_W-1:0] fb[$];
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic              use_ack;
        int                n;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do b = 8'($urandom); while (b == cfg_model.start_char);
                fb.push_back(b);
            end
        end
        n = $urandom_range(0, 99);
        if (n < 10)
            len = 8'($urandom_range(0, 3));
        else if (n < 95)
            len = 8'($urandom_range(4, 12));
        else
            len = 8'($urandom_range(13, 255));
        fb.push_back(cfg_model.start_char);
        fb.push_back(len);
        b = 8'($urandom);
        fb.push_back(b);
        sum = b;
        b = 8'($urandom);
        fb.push_back(b);
        sum = sum + b;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                do b = 8'($urandom);
                while (b == cfg_model.ack_char || b == cfg_model.nak_char);
                fb.push_back(b);
            end
        end
        use_ack = ($urandom_range(0, 9) < 6) || (cfg_model.ack_char == cfg_model.nak_char);
        if (use_ack) begin
            fb.push_back(cfg_model.ack_char);
            sum = sum + cfg_model.ack_char;
            if (len > 3) begin
                repeat (len - 3) begin
                    b = 8'($urandom);
                    fb.push_back(b);
                    sum = sum + b;
                end
            end
        end else begin
            fb.push_back(cfg_model.nak_char);
            sum = sum + cfg_model.nak_char;
            b = 8'($urandom);
            fb.push_back(b);
            sum = sum + b;
        end
        b = SUM_GOOD - sum;
        if ($urandom_range(0, 9) == 0)
            b = 8'($urandom);
        fb.push_back(b);
        b = cfg_model.end_char;
        if ($urandom_range(0, 9) == 0)
            b = 8'($urandom);
        fb.push_back(b);
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(1, fb.size()) : fb.size();
        for (int i = 0; i < n; i++)
            send_byte(fb[i], 1'b0, '0);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // result checker and output stall pattern
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (res_ch.valid && sink_ready) begin
                if (expected_fields.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got kind %0h byte %0h",
                             $time, res_ch.field_kind, res_ch.field_byte);
                    fail_count++;
                end else begin
                    want = expected_fields.pop_front();
                    check_field("field_kind", 8'(want.field_kind), 8'(res_ch.field_kind));
                    check_field("field_byte", want.field_byte, res_ch.field_byte);
                    check_field("frame_done", 8'(want.frame_done), 8'(res_ch.frame_done));
                    check_field("frame_good", 8'(want.frame_good), 8'(res_ch.frame_good));
                    check_field("checksum_ok", 8'(want.checksum_ok), 8'(res_ch.checksum_ok));
                    check_field("was_ack", 8'(want.was_ack), 8'(res_ch.was_ack));
                end
            end
            stall_cnt <= stall_cnt + 10'd1;
            case (stall_cnt[9:8])
                2'd0:    sink_ready <= 1'b1;
                2'd1:    sink_ready <= 1'($urandom_range(0, 1));
                2'd2:    sink_ready <= ($urandom_range(0, 7) != 0);
                default: sink_ready <= (stall_cnt[3:0] < 4'd4);
            endcase
        end
    end

    initial begin
        t_cfg        c;
        int unsigned base;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_START;
        cfg_data      = '0;
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].want);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: c = '{8'h00, 8'hFF, 8'hFF, 8'h00};
                1: c = '{8'hFF, 8'h00, 8'h00, 8'hFF};
                default: begin
                    c.start_char = 8'($urandom);
                    c.end_char   = 8'($urandom);
                    c.ack_char   = 8'($urandom);
                    c.nak_char   = 8'($urandom);
                    // same byte for both types in the last setting
                    if (p == 4)
                        c.nak_char = c.ack_char;
                end
            endcase
            write_all(c);
            base = items_sent;
            while (items_sent - base < PHASE_ITEMS)
                send_frame();
        end

        rx_ch.valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("sum_checksum_frame_receiver test passed");
        else
            $display("sum_checksum_frame_receiver test failed");
        $finish;
    end

endmodule
